@@ sv/srat_pkg.sv @@
// Shared types and constants of the sensor report aggregation table.
// Holds the request and result layouts, status codes and controller links.
// No dependencies; compiled first.
package srat_pkg;

  localparam int unsigned TableEntriesDef = 8;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned EpW     = 8;
  localparam int unsigned TypeW   = 8;
  localparam int unsigned AttrW   = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatW   = 4;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned MaskW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OpReport   = 2'd0;
  localparam opcode_t OpAnnounce = 2'd1;
  localparam opcode_t OpLeave    = 2'd2;
  localparam opcode_t OpUnused   = 2'd3;

  localparam logic [StatW-1:0] StPartial     = 4'd0;
  localparam logic [StatW-1:0] StComplete    = 4'd1;
  localparam logic [StatW-1:0] StMismatch    = 4'd2;
  localparam logic [StatW-1:0] StBadValue    = 4'd3;
  localparam logic [StatW-1:0] StFull        = 4'd4;
  localparam logic [StatW-1:0] StUnknownAttr = 4'd5;
  localparam logic [StatW-1:0] StRegistered  = 4'd6;
  localparam logic [StatW-1:0] StRemoved     = 4'd7;
  localparam logic [StatW-1:0] StNotFound    = 4'd8;

  localparam logic [CfgIdxW-1:0] CfgIdxCluster = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxType    = 1'b1;

  localparam logic [AddrW-1:0] ClusterRst = 16'hFC01;
  localparam logic [TypeW-1:0] TypeRst    = 8'd57;
  localparam logic [AddrW-1:0] AddrFree   = 16'hFFFF;
  localparam logic [MaskW-1:0] MaskFull   = 3'b111;
  localparam logic [AttrW-1:0] AttrOne    = 16'd1;
  localparam logic [AttrW-1:0] AttrTwo    = 16'd2;
  localparam logic [AttrW-1:0] AttrThree  = 16'd3;

  typedef struct packed {
    opcode_t          opcode;
    logic [AddrW-1:0] source_addr;
    logic [EpW-1:0]   endpoint;
    logic [AddrW-1:0] cluster_id;
    logic [TypeW-1:0] value_type;
    logic             value_ok;
    logic [AttrW-1:0] attr_id;
    logic [ValW-1:0]  value_bits;
  } srat_in_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] node_addr;
    logic [EpW-1:0]   node_endpoint;
    logic [ValW-1:0]  reading_one;
    logic [ValW-1:0]  reading_two;
    logic [ValW-1:0]  reading_three;
    logic [MaskW-1:0] arrived_mask;
  } srat_out_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic load_out;
  } srat_cmd_t;

  typedef struct packed {
    logic in_drop;
    logic out_free;
  } srat_sts_t;

endpackage

@@ sv/srat_intf.sv @@
// Channel interfaces: request in, result out, configuration write.
// Depends on srat_pkg for payload types.
interface srat_req_if;
  import srat_pkg::*;
  logic     valid;
  logic     ready;
  srat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srat_rsp_if;
  import srat_pkg::*;
  logic      valid;
  logic      ready;
  srat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srat_cfg_if;
  import srat_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/sensor_report_aggregation_table.sv @@
// Top level of the sensor report aggregation table.
// Depends on srat_pkg, srat_intf, srat_ctrl and srat_dp.
// Usage:
//   req_i  - request channel (valid/ready): one report, announce or leave.
//   rsp_o  - result channel (valid/ready): one result per request; requests
//            with the unused opcode are taken and dropped without a result.
//   cfg_i  - configuration writes (index 0 expected cluster, 1 expected type);
//            always ready, write only while no request is in flight.
// Timing:
//   A request is taken on a valid/ready handshake, the table is searched as it is taken,
//   updated in the next, and the result is loaded into the output register
//   once that register is free; rsp_o.valid rises as it is loaded. A request
//   is taken only after the previous one was updated and its result loaded.
//   A new request may be taken while the previous result still waits.
// Stall: a held-off result sits in the output register; a second result
//   waits in the datapath with req_i.ready low until the register frees.
// Reset:
//   Asynchronous, active low. Table emptied (all addresses 0xFFFF), config
//   back to cluster 0xFC01 and type 57. Reading memory is not cleared; its
//   contents are only used after all three readings of an entry were written.
module sensor_report_aggregation_table #(
  parameter int unsigned TABLE_ENTRIES = srat_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srat_req_if.sink    req_i,
  srat_rsp_if.source  rsp_o,
  srat_cfg_if.sink    cfg_i
);
  import srat_pkg::*;

  srat_cmd_t cmd;
  srat_sts_t sts;
  logic      in_ready;

  // config port never stalls
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = in_ready;

  srat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srat_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_data_o  (rsp_o.data)
  );

endmodule

@@ sv/srat_ctrl.sv @@
// Sequencing controller: accept, table update, result load.
// Depends on srat_pkg for the command and status structs.
module srat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srat_pkg::srat_sts_t sts_i,
  output srat_pkg::srat_cmd_t cmd_o
);
  import srat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q && !sts_i.in_drop) begin
            state_q    <= S_UPDATE;
            in_ready_q <= 1'b0;
          end
        end
        S_UPDATE: state_q <= S_DONE;
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = in_ready_q;
  assign cmd_o.capture    = in_valid_i & in_ready_q & ~sts_i.in_drop;
  assign cmd_o.update     = (state_q == S_UPDATE);
  assign cmd_o.load_out   = (state_q == S_DONE) & sts_i.out_free;

endmodule

@@ sv/srat_dp.sv @@
// Datapath: node table, address search, reading memory, result register.
// Depends on srat_pkg; driven by srat_ctrl commands.
module srat_dp #(
  parameter int unsigned TABLE_ENTRIES = srat_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srat_pkg::srat_in_t            in_data_i,
  input  logic                          cfg_we_i,
  input  logic [srat_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srat_pkg::CfgW-1:0]     cfg_data_i,
  input  srat_pkg::srat_cmd_t           cmd_i,
  output srat_pkg::srat_sts_t           sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output srat_pkg::srat_out_t           out_data_o
);
  import srat_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // configuration
  logic [AddrW-1:0] exp_cluster_q;
  logic [TypeW-1:0] exp_type_q;

  // node table
  logic             valid_q [TABLE_ENTRIES];
  logic [AddrW-1:0] addr_q  [TABLE_ENTRIES];
  logic [EpW-1:0]   ep_q    [TABLE_ENTRIES];
  logic [MaskW-1:0] mask_q  [TABLE_ENTRIES];

  // readings, one row per entry
  logic [2:0][ValW-1:0] rd_mem [TABLE_ENTRIES];
  logic [2:0][ValW-1:0] rd_q;

  // captured request and search result
  srat_in_t         item_q;
  logic             hit_q, free_q;
  logic [IdxW-1:0]  hit_idx_q, free_idx_q;
  logic [EpW-1:0]   hit_ep_q;
  logic [MaskW-1:0] hit_mask_q;

  // pending result
  logic [StatW-1:0] res_status_q;
  logic [SlotW-1:0] res_slot_q;
  logic [EpW-1:0]   res_ep_q;
  logic [MaskW-1:0] res_mask_q;
  logic             complete_q;
  logic [2:0]       wr_sel_q;

  srat_out_t out_q;
  logic      out_valid_q;

  // search on the incoming request
  logic            hit_d, free_d;
  logic [IdxW-1:0] hit_idx_d, free_idx_d;

  always_comb begin
    hit_d      = 1'b0;
    free_d     = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (addr_q[i] == in_data_i.source_addr)) begin
        hit_d     = 1'b1;
        hit_idx_d = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_d     = 1'b1;
        free_idx_d = IdxW'(i);
      end
    end
  end

  // update decision
  logic             is_rep, is_ann, is_lv, cfg_ok, claim, attr_known;
  logic             touched, complete, wr_en;
  logic [2:0]       attr_sel;
  logic [IdxW-1:0]  slot_idx;
  logic [MaskW-1:0] old_mask, new_mask, arrived;
  logic [StatW-1:0] status;
  logic [EpW-1:0]   node_ep;

  always_comb begin
    is_rep   = (item_q.opcode == OpReport);
    is_ann   = (item_q.opcode == OpAnnounce);
    is_lv    = (item_q.opcode == OpLeave);
    cfg_ok   = (item_q.cluster_id == exp_cluster_q) && (item_q.value_type == exp_type_q);
    claim    = is_ann || (is_rep && cfg_ok && item_q.value_ok);
    attr_sel = {item_q.attr_id == AttrThree,
                item_q.attr_id == AttrTwo,
                item_q.attr_id == AttrOne};
    attr_known = |attr_sel;
    slot_idx = hit_q ? hit_idx_q : free_idx_q;
    old_mask = hit_q ? hit_mask_q : '0;
    new_mask = old_mask | attr_sel;
    complete = attr_known && (new_mask == MaskFull);
    touched  = (is_lv && hit_q) || (claim && (hit_q || free_q));
    wr_en    = claim && touched && is_rep && attr_known;

    priority if (is_rep && !cfg_ok)        status = StMismatch;
    else if (is_rep && !item_q.value_ok)   status = StBadValue;
    else if (is_lv)                        status = hit_q ? StRemoved : StNotFound;
    else if (!(hit_q || free_q))           status = StFull;
    else if (is_ann)                       status = StRegistered;
    else if (!attr_known)                  status = StUnknownAttr;
    else if (complete)                     status = StComplete;
    else                                   status = StPartial;

    if (!touched)   arrived = '0;
    else if (wr_en) arrived = new_mask;
    else            arrived = old_mask;

    if (!touched)   node_ep = '0;
    else if (is_lv) node_ep = hit_ep_q;
    else            node_ep = item_q.endpoint;
  end

  assign sts_o.in_drop  = (in_data_i.opcode == OpUnused);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cluster_q <= ClusterRst;
      exp_type_q    <= TypeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxCluster: exp_cluster_q <= cfg_data_i;
        CfgIdxType:    exp_type_q    <= cfg_data_i[TypeW-1:0];
        default: ;
      endcase
    end
  end

  // table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        addr_q[i]  <= AddrFree;
        ep_q[i]    <= '0;
        mask_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      if (claim && touched) begin
        ep_q[slot_idx] <= item_q.endpoint;
        if (!hit_q) begin
          valid_q[slot_idx] <= 1'b1;
          addr_q[slot_idx]  <= item_q.source_addr;
        end
        if (wr_en) begin
          mask_q[slot_idx] <= complete ? '0 : new_mask;
        end else if (!hit_q) begin
          mask_q[slot_idx] <= '0;
        end
      end
      if (is_lv && hit_q) begin
        valid_q[hit_idx_q] <= 1'b0;
        addr_q[hit_idx_q]  <= AddrFree;
      end
    end
  end

  // reading memory: lane write, registered row read (old data on a clash)
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rd_q <= rd_mem[slot_idx];
      for (int k = 0; k < 3; k++) begin
        if (wr_en && attr_sel[k]) begin
          rd_mem[slot_idx][k] <= item_q.value_bits;
        end
      end
    end
  end

  // request capture and pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q     <= in_data_i;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      hit_ep_q   <= ep_q[hit_idx_d];
      hit_mask_q <= mask_q[hit_idx_d];
    end
    if (cmd_i.update) begin
      res_status_q <= status;
      res_slot_q   <= touched ? SlotW'(slot_idx) : '0;
      res_ep_q     <= node_ep;
      res_mask_q   <= arrived;
      complete_q   <= wr_en && complete;
      wr_sel_q     <= wr_en ? attr_sel : 3'b000;
    end
  end

  // result register; written lane bypasses the memory read
  logic [2:0][ValW-1:0] readings;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!complete_q)      readings[k] = '0;
      else if (wr_sel_q[k]) readings[k] = item_q.value_bits;
      else                  readings[k] = rd_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status        <= res_status_q;
      out_q.slot          <= res_slot_q;
      out_q.node_addr     <= item_q.source_addr;
      out_q.node_endpoint <= res_ep_q;
      out_q.reading_one   <= readings[0];
      out_q.reading_two   <= readings[1];
      out_q.reading_three <= readings[2];
      out_q.arrived_mask  <= res_mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/sensor_report_aggregation_table_tb.sv @@
// Self-checking testbench for the sensor report aggregation table.
// Depends on srat_pkg, the srat_*_if interfaces and the RTL top level.
// Random requests are predicted against a behavioural copy of the node table.
module sensor_report_aggregation_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srat_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned RstCycles   = 6;
  localparam int unsigned IdlePct     = 18;
  localparam int unsigned SettleCyc   = 12;
  localparam int unsigned PhaseReqs   = 488;  // four random phases, ~1950 requests
  localparam int unsigned HotAddrs    = 6;
  localparam int unsigned PoolAddrs   = 12;
  localparam int unsigned NumReadings = 3;

  logic clk = 1'b0;
  logic rst_n;

  srat_req_if req_if ();
  srat_rsp_if rsp_if ();
  srat_cfg_if cfg_if ();

  sensor_report_aggregation_table u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #ClkHalf clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the node table and of the two filter registers
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0] cfg_cluster;
  logic [TypeW-1:0] cfg_type;

  logic             node_live     [TableEntriesDef];
  logic [AddrW-1:0] node_addr_tbl [TableEntriesDef];
  logic [EpW-1:0]   node_ep       [TableEntriesDef];
  logic [MaskW-1:0] node_mask     [TableEntriesDef];
  // Readings are only ever read once all three were written since the mask cleared,
  // so the unwritten contents never matter.
  logic [ValW-1:0]  node_reading  [TableEntriesDef][NumReadings];

  srat_in_t  pending_requests [$];
  srat_out_t expected_results [$];

  logic [AddrW-1:0] hot_addr [PoolAddrs];

  int  accepted_count = 0;
  int  fail_count     = 0;
  logic steady;

  // Long window with no idling on either side.
  assign steady = (accepted_count >= 700) && (accepted_count < 1000);

  // First valid entry carrying this address, -1 if none.
  function automatic int find_node(input logic [AddrW-1:0] addr);
    for (int i = 0; i < TableEntriesDef; i++) begin
      if (node_live[i] && node_addr_tbl[i] == addr) return i;
    end
    return -1;
  endfunction

  // Match refreshes the endpoint; a miss claims the first free entry with a clean mask.
  function automatic int find_or_claim(input logic [AddrW-1:0] addr, input logic [EpW-1:0] ep);
    int hit;
    hit = find_node(addr);
    if (hit >= 0) begin
      node_ep[hit] = ep;
      return hit;
    end
    for (int i = 0; i < TableEntriesDef; i++) begin
      if (!node_live[i]) begin
        node_live[i]     = 1'b1;
        node_addr_tbl[i] = addr;
        node_ep[i]       = ep;
        node_mask[i]     = '0;
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one request to the shadow table; returns 0 when no result is due.
  function automatic bit predict_table_result(input srat_in_t req, output srat_out_t res);
    int hit;
    int idx;
    res = '0;
    hit = -1;
    if (req.opcode == OpUnused) return 1'b0;
    res.node_addr = req.source_addr;
    case (req.opcode)
      OpReport: begin
        // filter first, then payload length; neither touches the table
        if (req.cluster_id != cfg_cluster || req.value_type != cfg_type) begin
          res.status = StMismatch;
        end else if (!req.value_ok) begin
          res.status = StBadValue;
        end else begin
          hit = find_or_claim(req.source_addr, req.endpoint);
          if (hit < 0) begin
            res.status = StFull;
          end else if (req.attr_id >= AttrOne && req.attr_id <= AttrThree) begin
            idx = int'(req.attr_id) - 1;
            node_reading[hit][idx] = req.value_bits;
            node_mask[hit][idx]    = 1'b1;
            res.arrived_mask       = node_mask[hit];
            if (node_mask[hit] == MaskFull) begin
              res.status        = StComplete;
              res.reading_one   = node_reading[hit][0];
              res.reading_two   = node_reading[hit][1];
              res.reading_three = node_reading[hit][2];
              node_mask[hit]    = '0;
            end else begin
              res.status = StPartial;
            end
          end else begin
            // entry still found or added, nothing stored
            res.status       = StUnknownAttr;
            res.arrived_mask = node_mask[hit];
          end
        end
      end
      OpAnnounce: begin
        hit = find_or_claim(req.source_addr, req.endpoint);
        if (hit < 0) begin
          res.status = StFull;
        end else begin
          res.status       = StRegistered;
          res.arrived_mask = node_mask[hit];
        end
      end
      default: begin
        // leave: mask and readings stay behind in the freed entry
        hit = find_node(req.source_addr);
        if (hit < 0) begin
          res.status = StNotFound;
        end else begin
          res.status         = StRemoved;
          res.arrived_mask   = node_mask[hit];
          node_live[hit]     = 1'b0;
          node_addr_tbl[hit] = AddrFree;
        end
      end
    endcase
    if (hit >= 0) begin
      res.slot          = SlotW'(hit);
      res.node_endpoint = node_ep[hit];
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------
  function automatic srat_in_t make_req(input opcode_t op, input logic [AddrW-1:0] addr,
                                        input logic [EpW-1:0] ep, input logic [AttrW-1:0] attr,
                                        input logic [ValW-1:0] bits);
    srat_in_t r;
    r.opcode      = op;
    r.source_addr = addr;
    r.endpoint    = ep;
    r.cluster_id  = cfg_cluster;
    r.value_type  = cfg_type;
    r.value_ok    = 1'b1;
    r.attr_id     = attr;
    r.value_bits  = bits;
    return r;
  endfunction

  // Mostly the few hot nodes, so that readings complete often.
  function automatic logic [AddrW-1:0] pool_addr();
    if ($urandom_range(99) < 70) return hot_addr[$urandom_range(HotAddrs - 1)];
    return hot_addr[$urandom_range(PoolAddrs - 1)];
  endfunction

  function automatic srat_in_t random_request();
    srat_in_t     r;
    logic [127:0] noise;
    int           pick;
    r = make_req(OpReport, pool_addr(), EpW'($urandom), AttrW'($urandom_range(3, 1)),
                 $urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      // well-formed report
    end else if (pick < 66) begin
      r.attr_id = AttrW'($urandom);
    end else if (pick < 72) begin
      r.opcode = OpAnnounce;
    end else if (pick < 80) begin
      r.opcode = OpLeave;
    end else if (pick < 84) begin
      r.cluster_id = AddrW'($urandom);
    end else if (pick < 87) begin
      r.value_type = TypeW'($urandom);
    end else if (pick < 90) begin
      r.value_ok = 1'b0;
    end else if (pick < 93) begin
      r.opcode = OpUnused;
    end else begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      r     = noise[$bits(srat_in_t)-1:0];
      // keep stray announces from clogging the table
      if (r.opcode == OpAnnounce && $urandom_range(9) != 0) r.source_addr = pool_addr();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: feeds the queue into req_if
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    srat_out_t res;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (predict_table_result(req_if.data, res)) expected_results.push_back(res);
        accepted_count <= accepted_count + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          req_if.data  <= pending_requests.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : rsp_monitor
    srat_out_t want;
    srat_out_t got;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding, status 0x%0h", got.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("slot", want.slot, got.slot);
          check_field("node_addr", want.node_addr, got.node_addr);
          check_field("node_endpoint", want.node_endpoint, got.node_endpoint);
          check_field("reading_one", want.reading_one, got.reading_one);
          check_field("reading_two", want.reading_two, got.reading_two);
          check_field("reading_three", want.reading_three, got.reading_three);
          check_field("arrived_mask", want.arrived_mask, got.arrived_mask);
        end
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Sender empty and every result back; the extra cycles cover dropped unused opcodes
  // still in flight, since they never produce a result to wait for.
  task automatic wait_until_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CfgIdxCluster) begin
      cfg_cluster = value;
    end else begin
      cfg_type = value[TypeW-1:0];
    end
  endtask

  initial begin : stimulus
    srat_in_t r;
    int       counted;

    // everything known from time zero
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    cfg_cluster    = ClusterRst;
    cfg_type       = TypeRst;
    for (int i = 0; i < TableEntriesDef; i++) begin
      node_live[i]     = 1'b0;
      node_addr_tbl[i] = AddrFree;
      node_ep[i]       = '0;
      node_mask[i]     = '0;
    end
    repeat (RstCycles) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part, reset filter values ---
    // one node through all three readings, with an unknown attribute and
    // an endpoint change in the middle
    pending_requests.push_back(make_req(OpAnnounce, 16'h1234, 8'h01, 16'h0000, 32'h0));
    pending_requests.push_back(make_req(OpReport, 16'h1234, 8'h01, AttrOne, 32'hFFFF_FFFF));
    pending_requests.push_back(make_req(OpReport, 16'h1234, 8'h01, AttrTwo, 32'h3F80_0000));
    pending_requests.push_back(make_req(OpReport, 16'h1234, 8'hFF, 16'h0000, 32'h1));
    pending_requests.push_back(make_req(OpReport, 16'h1234, 8'h00, AttrThree, 32'h0));
    // filter order: wrong cluster, wrong type, short value, and both faults at once
    r = make_req(OpReport, 16'h1234, 8'h01, AttrOne, 32'h5);
    r.cluster_id = ~cfg_cluster;
    pending_requests.push_back(r);
    r.cluster_id = cfg_cluster;
    r.value_type = ~cfg_type;
    pending_requests.push_back(r);
    r.value_type = cfg_type;
    r.value_ok   = 1'b0;
    pending_requests.push_back(r);
    r.cluster_id = ~cfg_cluster;
    pending_requests.push_back(r);
    // the free-marker address as a real node, top attribute id
    pending_requests.push_back(make_req(OpReport, AddrFree, 8'h7F, 16'hFFFF, 32'h8000_0000));
    // leave of an absent node, then of a present one
    pending_requests.push_back(make_req(OpLeave, 16'h4321, 8'h00, 16'h0000, 32'h0));
    pending_requests.push_back(make_req(OpLeave, 16'h1234, 8'h00, 16'h0000, 32'h0));
    // unused opcode: swallowed
    pending_requests.push_back(make_req(OpUnused, 16'h1234, 8'h01, AttrOne, 32'hDEAD_BEEF));
    // fill the table, then a new node by announce and by report
    for (int i = 0; i < TableEntriesDef - 1; i++) begin
      pending_requests.push_back(make_req(OpAnnounce, AddrW'(i), EpW'(i + 8), 16'h0, 32'h0));
    end
    pending_requests.push_back(make_req(OpAnnounce, 16'hABCD, 8'h11, 16'h0000, 32'h0));
    pending_requests.push_back(make_req(OpReport, 16'hABCD, 8'h11, AttrOne, 32'h1234_5678));
    // a known node still gets through while the table is full
    pending_requests.push_back(make_req(OpReport, AddrFree, 8'h7E, AttrOne, 32'h4049_0FDB));
    pending_requests.push_back(make_req(OpLeave, AddrFree, 8'h00, 16'h0000, 32'h0));

    // --- random phases, filter registers moved between them ---
    for (int ph = 0; ph < 4; ph++) begin
      // full pause of the sender until every result is back
      wait_until_idle();
      case (ph)
        0: begin
          write_reg(CfgIdxCluster, 16'h0000);
          write_reg(CfgIdxType, 16'h0000);
        end
        1: begin
          write_reg(CfgIdxCluster, 16'hFFFF);
          write_reg(CfgIdxType, 16'hFFFF);
        end
        2: begin
          write_reg(CfgIdxCluster, CfgW'($urandom));
          write_reg(CfgIdxType, CfgW'($urandom));
        end
        default: begin
          write_reg(CfgIdxCluster, CfgW'(ClusterRst));
          write_reg(CfgIdxType, CfgW'(TypeRst));
        end
      endcase

      hot_addr[0] = 16'h0000;
      hot_addr[1] = AddrFree;
      for (int i = 2; i < PoolAddrs; i++) hot_addr[i] = AddrW'($urandom);

      // empty the table so the new address pool has room
      for (int i = 0; i < TableEntriesDef; i++) begin
        if (node_live[i]) begin
          pending_requests.push_back(make_req(OpLeave, node_addr_tbl[i], EpW'($urandom),
                                              AttrW'($urandom), $urandom));
        end
      end

      counted = 0;
      while (counted < PhaseReqs) begin
        r = random_request();
        pending_requests.push_back(r);
        if (r.opcode != OpUnused) counted++;
      end
    end

    wait_until_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~2000 requests).
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
